// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define NAFSM_ASSERT_IMP(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define NAFSM_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// ===== rtl/nafsm_pkg.sv =====
package nafsm_pkg;

	localparam int NBR_DEFAULT = 16;

	localparam int SLOT_W = 4;
	localparam int OP_W   = 4;
	localparam int RID_W  = 32;
	localparam int CNT_W  = 5;
	localparam int SEQ_W  = 8;
	localparam int ROLE_W = 3;
	localparam int CFG_IDX_W = 2;

	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 4;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [2:0] {
		ST_DOWN     = 3'd0,
		ST_ATTEMPT  = 3'd1,
		ST_INIT     = 3'd2,
		ST_TWOWAY   = 3'd3,
		ST_EXSTART  = 3'd4,
		ST_EXCHANGE = 3'd5,
		ST_LOADING  = 3'd6,
		ST_FULL     = 3'd7
	} nbr_state_t;

	typedef enum logic [OP_W-1:0] {
		OP_HELLO      = 4'd0,
		OP_START      = 4'd1,
		OP_TWOWAY     = 4'd2,
		OP_NEGDONE    = 4'd3,
		OP_EXDONE     = 4'd4,
		OP_BADLSREQ   = 4'd5,
		OP_LOADDONE   = 4'd6,
		OP_ADJOK      = 4'd7,
		OP_SEQMIS     = 4'd8,
		OP_ONEWAY     = 4'd9,
		OP_KILL       = 4'd10,
		OP_INACTIVITY = 4'd11,
		OP_LINKDOWN   = 4'd12
	} nbr_op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROLE = 2'd0,
		REG_DR   = 2'd1,
		REG_BDR  = 2'd2
	} cfg_reg_t;

	localparam logic [ROLE_W-1:0] ROLE_P2P        = 3'd3;
	localparam logic [ROLE_W-1:0] ROLE_OTHER      = 3'd4;
	localparam logic [ROLE_W-1:0] ROLE_BACKUP     = 3'd5;
	localparam logic [ROLE_W-1:0] ROLE_DESIGNATED = 3'd6;

	localparam logic [2:0] FLAGS_ALL = 3'b111;
	localparam logic [2:0] FLAG_INIT = 3'b100;
	localparam logic [2:0] FLAGS_NONE = 3'b000;
	localparam logic [SEQ_W-1:0] SEQ_EXSTART = 8'd112;
	localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

	typedef struct packed {
		nbr_state_t state;
		logic [2:0] flags;
	} nbr_entry_t;

	typedef struct packed {
		nbr_state_t       state;
		logic [2:0]       flags;
		logic [CNT_W-1:0] partial;
		logic [CNT_W-1:0] full;
		logic             change;
		logic             seq_hit;
	} move_t;

	typedef struct packed {
		logic             we;
		nbr_entry_t       entry;
		logic [CNT_W-1:0] partial;
		logic [CNT_W-1:0] full;
	} wb_t;

	typedef struct packed {
		nbr_state_t       prev_state;
		nbr_state_t       new_state;
		logic             neighbor_change;
		logic             restart_inactivity;
		logic             neighbor_removed;
		logic             unexpected_event;
		logic [CNT_W-1:0] partial_adjacencies;
		logic [CNT_W-1:0] full_adjacencies;
		logic [2:0]       dd_flags;
		logic [SEQ_W-1:0] dd_sequence;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? c : c + 5'd1;
	endfunction

	function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] c);
		return (c == '0) ? c : c - 5'd1;
	endfunction

	function automatic logic is_partial(input nbr_state_t s);
		return (s == ST_EXCHANGE) || (s == ST_LOADING);
	endfunction

	// One state move with its side effects on counts, flags and event bits.
	function automatic move_t apply_move(input move_t cur, input nbr_state_t target,
			input logic en);
		move_t m;
		m = cur;
		if (en && (target != cur.state)) begin
			m.state = target;
			if (is_partial(target))
				m.partial = sat_inc(m.partial);
			if (is_partial(cur.state))
				m.partial = sat_dec(m.partial);
			if (target == ST_FULL)
				m.full = sat_inc(m.full);
			if (cur.state == ST_FULL)
				m.full = sat_dec(m.full);
			if (target == ST_EXSTART) begin
				m.flags   = FLAGS_ALL;
				m.seq_hit = 1'b1;
			end
			if (target > ST_EXSTART)
				m.flags = m.flags & ~FLAG_INIT;
			if (((target == ST_TWOWAY) && (cur.state < ST_TWOWAY)) ||
					((target < ST_TWOWAY) && (cur.state >= ST_TWOWAY)))
				m.change = 1'b1;
		end
		return m;
	endfunction

endpackage

// ===== rtl/neighbor_adjacency_fsm_unit.sv =====
// Channel   Dir  Transaction contents (low bit first)
// s_axis    in   tdata: neighbor_slot[3:0], neighbor_router_id[35:4]; tuser: operation[3:0]
// m_axis    out  tdata: one result per event, see port comment
// cfg       in   cfg_index 0 interface_role, 1 dr_router_id, 2 bdr_router_id
//
// Events pass stage 1 and the output register; one event per cycle unless the output stalls.
// Stage 1 holds the event; the table read-modify-write and the result register load
// share the same edge, so the next event always sees the updated entry and counts.
// A stalled result holds in the output register; stage 1 keeps taking a new event
// whenever it is empty or moves on into the output register.
// Reset (arst_n low) clears all slots to Down with zero flags, both counts, cfg and valid bits.

`include "assert_macros.svh"

module neighbor_adjacency_fsm_unit import nafsm_pkg::*; #(
	parameter int NEIGHBORS = NBR_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [RID_W-1:0]      cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// neighbor_slot[3:0], neighbor_router_id[35:4], zero pad [39:36]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// operation[3:0]
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// prev_state[2:0], new_state[5:3], neighbor_change[6], restart_inactivity[7],
	// neighbor_removed[8], unexpected_event[9], partial_adjacencies[14:10],
	// full_adjacencies[19:15], dd_flags[22:20], dd_sequence[30:23], zero pad [31]
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int IDX_W = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
	localparam logic [8:0] NBR_LIMIT = 9'(NEIGHBORS);

	// configuration registers
	logic [ROLE_W-1:0] role_q;
	logic [RID_W-1:0]  dr_q;
	logic [RID_W-1:0]  bdr_q;

	// stage 1: captured event
	logic              valid_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [OP_W-1:0]   op_s1;
	logic [RID_W-1:0]  rid_s1;

	// output register
	logic    out_valid_q;
	result_t out_q;

	logic             advance_s1;
	logic             slot_ok;
	logic [IDX_W-1:0] idx;
	nbr_entry_t       entry;
	logic [CNT_W-1:0] partial;
	logic [CNT_W-1:0] full;
	wb_t              wb;
	result_t          res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q <= '0;
			dr_q   <= '0;
			bdr_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROLE: role_q <= cfg_data[ROLE_W-1:0];
				REG_DR:   dr_q   <= cfg_data;
				REG_BDR:  bdr_q  <= cfg_data;
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	// Advance stage 1 when the output register is empty or being drained.
	assign advance_s1    = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			slot_s1 <= s_axis_tdata[SLOT_W-1:0];
			rid_s1  <= s_axis_tdata[SLOT_W+RID_W-1:SLOT_W];
			op_s1   <= s_axis_tuser[OP_W-1:0];
		end
	end

	// Slots past the table depth touch nothing.
	assign slot_ok = {5'd0, slot_s1} < NBR_LIMIT;
	assign idx     = slot_ok ? IDX_W'(slot_s1) : '0;

	nafsm_table #(
		.NEIGHBORS(NEIGHBORS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (idx),
		.wb     (wb),
		.entry  (entry),
		.partial(partial),
		.full   (full)
	);

	nafsm_eval u_eval (
		.fire   (advance_s1),
		.slot_ok(slot_ok),
		.op     (op_s1),
		.rid    (rid_s1),
		.role   (role_q),
		.dr_id  (dr_q),
		.bdr_id (bdr_q),
		.entry  (entry),
		.partial(partial),
		.full   (full),
		.wb     (wb),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q.dd_sequence, out_q.dd_flags, out_q.full_adjacencies,
		out_q.partial_adjacencies, out_q.unexpected_event, out_q.neighbor_removed,
		out_q.restart_inactivity, out_q.neighbor_change, out_q.new_state, out_q.prev_state};

	`NAFSM_ASSERT_IMP(a_wb_only_on_advance, clk, arst_n, wb.we, advance_s1,
		"table write without advance")
	`NAFSM_ASSERT_NEXT(a_counts_hold, clk, arst_n, !wb.we,
		$stable(partial) && $stable(full), "counts moved without a table write")
	`NAFSM_ASSERT_IMP(a_seq_on_exstart, clk, arst_n,
		m_axis_tvalid && (out_q.dd_sequence != 8'd0),
		(out_q.new_state == ST_EXSTART) && (out_q.prev_state != ST_EXSTART),
		"sequence without ExStart entry")
	`NAFSM_ASSERT_IMP(a_removed_down, clk, arst_n, m_axis_tvalid && out_q.neighbor_removed,
		(out_q.new_state == ST_DOWN) && (out_q.dd_flags == FLAGS_NONE),
		"removed slot not cleared")

endmodule

// ===== rtl/nafsm_table.sv =====
module nafsm_table import nafsm_pkg::*; #(
	parameter int NEIGHBORS = NBR_DEFAULT
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic [(NEIGHBORS > 1 ? $clog2(NEIGHBORS) : 1)-1:0] idx,
	input  wb_t                                         wb,
	output nbr_entry_t                                  entry,
	output logic [CNT_W-1:0]                            partial,
	output logic [CNT_W-1:0]                            full
);

	nbr_entry_t       entry_q [NEIGHBORS];
	logic [CNT_W-1:0] partial_q;
	logic [CNT_W-1:0] full_q;

	assign entry   = entry_q[idx];
	assign partial = partial_q;
	assign full    = full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NEIGHBORS; i++) begin
				entry_q[i] <= '{state: ST_DOWN, flags: FLAGS_NONE};
			end
			partial_q <= '0;
			full_q    <= '0;
		end else if (wb.we) begin
			entry_q[idx] <= wb.entry;
			partial_q    <= wb.partial;
			full_q       <= wb.full;
		end
	end

endmodule

// ===== rtl/nafsm_eval.sv =====
module nafsm_eval import nafsm_pkg::*; (
	input  logic              fire,
	input  logic              slot_ok,
	input  logic [OP_W-1:0]   op,
	input  logic [RID_W-1:0]  rid,
	input  logic [ROLE_W-1:0] role,
	input  logic [RID_W-1:0]  dr_id,
	input  logic [RID_W-1:0]  bdr_id,
	input  nbr_entry_t        entry,
	input  logic [CNT_W-1:0]  partial,
	input  logic [CNT_W-1:0]  full,
	output wb_t               wb,
	output result_t           res
);

	move_t      m0;
	move_t      ma;
	move_t      m1;
	nbr_state_t s;
	logic       adj_base;
	logic       restart;
	logic       removed;
	logic       unexpected;

	// Role test; the state part of the adjacency check is done per event.
	always_comb begin
		unique case (role)
			ROLE_P2P, ROLE_BACKUP, ROLE_DESIGNATED: adj_base = 1'b1;
			ROLE_OTHER: adj_base = (rid == dr_id) || (rid == bdr_id);
			default: adj_base = 1'b0;
		endcase
	end

	always_comb begin
		s          = entry.state;
		m0         = '{state: entry.state, flags: entry.flags, partial: partial, full: full,
			change: 1'b0, seq_hit: 1'b0};
		ma         = m0;
		m1         = m0;
		restart    = 1'b0;
		removed    = 1'b0;
		unexpected = 1'b0;
		unique case (op)
			OP_START: m1 = apply_move(m0, ST_ATTEMPT, 1'b1);
			OP_HELLO: begin
				m1      = apply_move(m0, ST_INIT, s < ST_INIT);
				restart = 1'b1;
			end
			OP_TWOWAY: begin
				// up to 2-Way first, then on to ExStart if adjacency is allowed
				ma = apply_move(m0, ST_TWOWAY, s < ST_TWOWAY);
				m1 = apply_move(ma, ST_EXSTART, (ma.state == ST_TWOWAY) && adj_base);
			end
			OP_NEGDONE: begin
				m1         = apply_move(m0, ST_EXCHANGE, s == ST_EXSTART);
				unexpected = (s != ST_EXSTART);
			end
			OP_EXDONE, OP_LOADDONE: m1 = apply_move(m0, ST_FULL, 1'b1);
			OP_ADJOK: begin
				if ((s == ST_TWOWAY) && adj_base)
					m1 = apply_move(m0, ST_EXSTART, 1'b1);
				else if ((s >= ST_EXSTART) && !adj_base)
					m1 = apply_move(m0, ST_TWOWAY, 1'b1);
			end
			OP_BADLSREQ, OP_SEQMIS: m1 = apply_move(m0, ST_EXSTART, s >= ST_EXCHANGE);
			OP_KILL, OP_INACTIVITY, OP_LINKDOWN: begin
				m1       = apply_move(m0, ST_DOWN, 1'b1);
				m1.flags = FLAGS_NONE;
				removed  = 1'b1;
			end
			OP_ONEWAY: m1 = apply_move(m0, ST_INIT, 1'b1);
			default: unexpected = 1'b1;
		endcase
	end

	always_comb begin
		wb.we          = fire && slot_ok;
		wb.entry.state = m1.state;
		wb.entry.flags = m1.flags;
		wb.partial     = m1.partial;
		wb.full        = m1.full;

		res.partial_adjacencies = slot_ok ? m1.partial : partial;
		res.full_adjacencies    = slot_ok ? m1.full : full;
		if (slot_ok) begin
			res.prev_state         = s;
			res.new_state          = m1.state;
			res.neighbor_change    = m1.change;
			res.restart_inactivity = restart;
			res.neighbor_removed   = removed;
			res.unexpected_event   = unexpected;
			res.dd_flags           = m1.flags;
			res.dd_sequence        = m1.seq_hit ? SEQ_EXSTART : '0;
		end else begin
			// slot outside the table: report nothing, counts as held
			res.prev_state         = ST_DOWN;
			res.new_state          = ST_DOWN;
			res.neighbor_change    = 1'b0;
			res.restart_inactivity = 1'b0;
			res.neighbor_removed   = 1'b0;
			res.unexpected_event   = 1'b0;
			res.dd_flags           = FLAGS_NONE;
			res.dd_sequence        = '0;
		end
	end

endmodule

// ===== sim/tb_neighbor_adjacency_fsm_unit.sv =====
// Checks the neighbor adjacency state machine against a cycle-free
// prediction of the neighbor table, the adjacency counts and the
// database-description flags. Each accepted event transaction is
// predicted on acceptance. Each result transaction is compared field by
// field with the oldest prediction still waiting.
module tb_neighbor_adjacency_fsm_unit import nafsm_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// Roles without a name in the package
	localparam logic [ROLE_W-1:0] ROLE_DOWN     = 3'd0;
	localparam logic [ROLE_W-1:0] ROLE_LOOPBACK = 3'd1;
	localparam logic [ROLE_W-1:0] ROLE_WAITING  = 3'd2;

	// Event codes past linkdown are undefined and must flag an unexpected event
	localparam logic [OP_W-1:0] OP_UNDEF_13 = 4'd13;
	localparam logic [OP_W-1:0] OP_UNDEF_14 = 4'd14;
	localparam logic [OP_W-1:0] OP_UNDEF_15 = 4'd15;

	localparam int TABLE_SIZE  = 16;
	localparam int BLOCK_ITEMS = 60;
	localparam int NUM_BLOCKS  = 8;

	typedef struct {
		logic [SLOT_W-1:0] slot;
		logic [OP_W-1:0]   op;
		logic [RID_W-1:0]  rid;
	} nbr_event_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [RID_W-1:0]      cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// Mirror of the neighbor table and the interface registers
	nbr_state_t       tbl_state [TABLE_SIZE];
	logic [2:0]       tbl_flags [TABLE_SIZE];
	logic [CNT_W-1:0] partial_cnt;
	logic [CNT_W-1:0] full_cnt;
	logic [ROLE_W-1:0] cur_role;
	logic [RID_W-1:0]  cur_dr;
	logic [RID_W-1:0]  cur_bdr;

	nbr_event_t queued_events [$];
	result_t    predicted_results [$];
	nbr_event_t on_bus;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;

	neighbor_adjacency_fsm_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("[neighbor_adjacency_fsm_unit] ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	// Adjacency needs 2-Way or above; role other also needs the neighbor to be DR or BDR
	function automatic logic adjacency_allowed(input int s, input logic [RID_W-1:0] rid);
		logic up;
		up = (tbl_state[s] >= ST_TWOWAY);
		case (cur_role)
			ROLE_OTHER:                            return up && (rid == cur_dr || rid == cur_bdr);
			ROLE_P2P, ROLE_BACKUP, ROLE_DESIGNATED: return up;
			default:                               return 1'b0;
		endcase
	endfunction

	// Move one slot, keeping counts, flags and event bits in step
	function automatic void shift_state(input int s, input nbr_state_t tgt,
			inout logic chg, inout logic seq_hit);
		nbr_state_t cur;
		cur = tbl_state[s];
		if (tgt == cur)
			return;
		tbl_state[s] = tgt;
		if ((tgt == ST_EXCHANGE || tgt == ST_LOADING) && partial_cnt != CNT_MAX)
			partial_cnt++;
		if ((cur == ST_EXCHANGE || cur == ST_LOADING) && partial_cnt != 0)
			partial_cnt--;
		if (tgt == ST_FULL && full_cnt != CNT_MAX)
			full_cnt++;
		if (cur == ST_FULL && full_cnt != 0)
			full_cnt--;
		if (tgt == ST_EXSTART) begin
			tbl_flags[s] = FLAGS_ALL;
			seq_hit = 1'b1;
		end
		if (tgt > ST_EXSTART)
			tbl_flags[s] = tbl_flags[s] & ~FLAG_INIT;
		// crossing the 2-Way line in either direction wakes up the interface
		if ((tgt == ST_TWOWAY && cur < ST_TWOWAY) || (tgt < ST_TWOWAY && cur >= ST_TWOWAY))
			chg = 1'b1;
	endfunction

	function automatic result_t predict_transition(input nbr_event_t ev);
		result_t r;
		logic chg;
		logic seq_hit;
		int s;
		r = '0;
		chg = 1'b0;
		seq_hit = 1'b0;
		s = int'(ev.slot);
		r.prev_state = tbl_state[s];
		case (ev.op)
			OP_START: shift_state(s, ST_ATTEMPT, chg, seq_hit);
			OP_HELLO: begin
				if (tbl_state[s] < ST_INIT)
					shift_state(s, ST_INIT, chg, seq_hit);
				r.restart_inactivity = 1'b1;
			end
			OP_TWOWAY: begin
				if (tbl_state[s] < ST_TWOWAY)
					shift_state(s, ST_TWOWAY, chg, seq_hit);
				if (tbl_state[s] == ST_TWOWAY && adjacency_allowed(s, ev.rid))
					shift_state(s, ST_EXSTART, chg, seq_hit);
			end
			OP_NEGDONE: begin
				if (tbl_state[s] == ST_EXSTART)
					shift_state(s, ST_EXCHANGE, chg, seq_hit);
				else
					r.unexpected_event = 1'b1;
			end
			OP_EXDONE, OP_LOADDONE: shift_state(s, ST_FULL, chg, seq_hit);
			OP_ADJOK: begin
				if (tbl_state[s] == ST_TWOWAY && adjacency_allowed(s, ev.rid))
					shift_state(s, ST_EXSTART, chg, seq_hit);
				else if (tbl_state[s] >= ST_EXSTART && !adjacency_allowed(s, ev.rid))
					shift_state(s, ST_TWOWAY, chg, seq_hit);
			end
			OP_BADLSREQ, OP_SEQMIS: begin
				if (tbl_state[s] >= ST_EXCHANGE)
					shift_state(s, ST_EXSTART, chg, seq_hit);
			end
			OP_KILL, OP_INACTIVITY, OP_LINKDOWN: begin
				shift_state(s, ST_DOWN, chg, seq_hit);
				tbl_flags[s] = FLAGS_NONE;
				r.neighbor_removed = 1'b1;
			end
			OP_ONEWAY: shift_state(s, ST_INIT, chg, seq_hit);
			default: r.unexpected_event = 1'b1;
		endcase
		r.new_state = tbl_state[s];
		r.neighbor_change = chg;
		r.partial_adjacencies = partial_cnt;
		r.full_adjacencies = full_cnt;
		r.dd_flags = tbl_flags[s];
		r.dd_sequence = seq_hit ? SEQ_EXSTART : '0;
		return r;
	endfunction

	// Driver: predict each accepted event, then present the next one or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predicted_results.push_back(predict_transition(on_bus));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (queued_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					on_bus = queued_events.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {4'b0, on_bus.rid, on_bus.slot};
					s_axis_tuser  <= on_bus.op;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result transaction, then stall or not at random
	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (predicted_results.size() == 0) begin
					report_mismatch("result with no event waiting");
				end else begin
					want = predicted_results.pop_front();
					check_field("prev_state", 32'(m_axis_tdata[2:0]),
						32'(want.prev_state));
					check_field("new_state", 32'(m_axis_tdata[5:3]),
						32'(want.new_state));
					check_field("neighbor_change", 32'(m_axis_tdata[6]),
						32'(want.neighbor_change));
					check_field("restart_inactivity", 32'(m_axis_tdata[7]),
						32'(want.restart_inactivity));
					check_field("neighbor_removed", 32'(m_axis_tdata[8]),
						32'(want.neighbor_removed));
					check_field("unexpected_event", 32'(m_axis_tdata[9]),
						32'(want.unexpected_event));
					check_field("partial_adjacencies", 32'(m_axis_tdata[14:10]),
						32'(want.partial_adjacencies));
					check_field("full_adjacencies", 32'(m_axis_tdata[19:15]),
						32'(want.full_adjacencies));
					check_field("dd_flags", 32'(m_axis_tdata[22:20]),
						32'(want.dd_flags));
					check_field("dd_sequence", 32'(m_axis_tdata[30:23]),
						32'(want.dd_sequence));
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	function automatic void add_event(input logic [SLOT_W-1:0] slot,
			input logic [OP_W-1:0] op, input logic [RID_W-1:0] rid);
		nbr_event_t ev;
		ev.slot = slot;
		ev.op = op;
		ev.rid = rid;
		queued_events.push_back(ev);
	endfunction

	// Lean toward the DR and BDR ids so role other reaches ExStart often
	function automatic logic [RID_W-1:0] pick_rid();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return cur_dr;
		if (r < 6)
			return cur_bdr;
		if (r == 6)
			return '0;
		if (r == 7)
			return '1;
		return $urandom;
	endfunction

	// Mostly full bring-ups with random tails, the rest single noise events
	function automatic void add_random_block(input int count);
		logic [SLOT_W-1:0] slot;
		logic [OP_W-1:0]   seq_ops [4];
		int tail;
		while (queued_events.size() < count) begin
			slot = SLOT_W'($urandom_range(0, TABLE_SIZE - 1));
			if ($urandom_range(0, 99) < 70) begin
				seq_ops[0] = OP_HELLO;
				seq_ops[1] = OP_TWOWAY;
				seq_ops[2] = OP_NEGDONE;
				seq_ops[3] = $urandom_range(0, 1) ? OP_EXDONE : OP_LOADDONE;
				foreach (seq_ops[i]) begin
					// break the sequence now and then
					if ($urandom_range(0, 99) < 8)
						seq_ops[i] = OP_W'($urandom_range(0, 15));
					add_event(slot, seq_ops[i], pick_rid());
				end
				tail = $urandom_range(0, 3);
				repeat (tail)
					add_event(slot, OP_W'($urandom_range(0, 15)), pick_rid());
			end else begin
				add_event(slot, OP_W'($urandom_range(0, 15)), pick_rid());
			end
		end
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [RID_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_ROLE: cur_role = val[ROLE_W-1:0];
			REG_DR:   cur_dr = val;
			REG_BDR:  cur_bdr = val;
			default:  ;
		endcase
	endtask

	task automatic apply_setting(input logic [ROLE_W-1:0] role,
			input logic [RID_W-1:0] dr, input logic [RID_W-1:0] bdr);
		write_reg(REG_ROLE, {29'b0, role});
		write_reg(REG_DR, dr);
		write_reg(REG_BDR, bdr);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every event is accepted and answered, then let the pipe settle
	task automatic wait_quiet();
		int guard;
		guard = 0;
		do begin
			@(negedge clk);
			guard++;
		end while ((queued_events.size() != 0 || s_axis_tvalid ||
				predicted_results.size() != 0) && guard < 200_000);
		repeat (6) @(negedge clk);
	endtask

	initial begin
		logic [ROLE_W-1:0] role_plan [NUM_BLOCKS];
		logic [RID_W-1:0]  dr_val;
		logic [RID_W-1:0]  bdr_val;
		role_plan = '{ROLE_DESIGNATED, ROLE_OTHER, ROLE_DOWN, ROLE_P2P,
			ROLE_BACKUP, ROLE_OTHER, ROLE_LOOPBACK, ROLE_WAITING};
		foreach (tbl_state[i]) begin
			tbl_state[i] = ST_DOWN;
			tbl_flags[i] = FLAGS_NONE;
		end
		partial_cnt = '0;
		full_cnt = '0;
		cur_role = ROLE_DOWN;
		cur_dr = '0;
		cur_bdr = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed walk: role other, DR at all ones, BDR at a fixed pattern
		apply_setting(ROLE_OTHER, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
		add_event(4'd0, OP_HELLO, 32'hFFFF_FFFF);      // Down to Init, restart timer
		add_event(4'd0, OP_TWOWAY, 32'hFFFF_FFFF);     // to 2-Way then ExStart via DR
		add_event(4'd0, OP_NEGDONE, 32'hFFFF_FFFF);    // into Exchange
		add_event(4'd0, OP_NEGDONE, 32'hFFFF_FFFF);    // negdone outside ExStart
		add_event(4'd0, OP_LOADDONE, 32'hFFFF_FFFF);   // Exchange to Full
		add_event(4'd0, OP_EXDONE, 32'hFFFF_FFFF);     // already Full: no change
		add_event(4'd0, OP_SEQMIS, 32'hFFFF_FFFF);     // back to ExStart
		add_event(4'd0, OP_ADJOK, 32'h1234_5678);      // adjacency lost: 2-Way
		add_event(4'd0, OP_ADJOK, 32'hFFFF_FFFF);      // adjacency again: ExStart
		add_event(4'd15, OP_START, 32'h0000_0000);     // Down to Attempt
		add_event(4'd15, OP_TWOWAY, 32'h0000_0000);    // 2-Way, no adjacency
		add_event(4'd15, OP_EXDONE, 32'h0000_0000);    // straight to Full
		add_event(4'd15, OP_BADLSREQ, 32'h0000_0000);  // Full to ExStart
		add_event(4'd15, OP_ONEWAY, 32'h0000_0000);    // drop below 2-Way
		add_event(4'd8, OP_HELLO, 32'h5A5A_A5A5);
		add_event(4'd8, OP_TWOWAY, 32'h5A5A_A5A5);     // ExStart via BDR
		add_event(4'd8, OP_NEGDONE, 32'h5A5A_A5A5);
		add_event(4'd0, OP_KILL, 32'hFFFF_FFFF);       // removal clears flags
		add_event(4'd15, OP_INACTIVITY, 32'h0000_0000);
		add_event(4'd8, OP_LINKDOWN, 32'h5A5A_A5A5);   // removal out of Exchange
		add_event(4'd0, OP_LINKDOWN, 32'hFFFF_FFFF);   // removal while already Down
		add_event(4'd7, OP_UNDEF_13, 32'hA5A5_5A5A);
		add_event(4'd7, OP_UNDEF_14, 32'hA5A5_5A5A);
		add_event(4'd7, OP_UNDEF_15, 32'hA5A5_5A5A);
		wait_quiet();

		// Random blocks: two register settings per idling mode
		for (int b = 0; b < NUM_BLOCKS; b++) begin
			case (b % 3)
				0: begin
					dr_val = '0;
					bdr_val = '1;
				end
				1: begin
					dr_val = '1;
					bdr_val = '0;
				end
				default: begin
					dr_val = $urandom;
					bdr_val = $urandom;
				end
			endcase
			case (b / 2)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 86;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 86;
				end
				default: begin
					send_idle_pct = 12;
					recv_stall_pct = 12;
				end
			endcase
			apply_setting(role_plan[b], dr_val, bdr_val);
			add_random_block(BLOCK_ITEMS);
			wait_quiet();
		end

		repeat (8) @(posedge clk);
		if (queued_events.size() != 0 || s_axis_tvalid)
			report_mismatch($sformatf("%0d events never accepted", queued_events.size()));
		if (predicted_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", predicted_results.size()));
		if (errors == 0)
			$display("[neighbor_adjacency_fsm_unit] OK");
		else
			$display("[neighbor_adjacency_fsm_unit] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/nafsm_pkg.sv
rtl/nafsm_table.sv
rtl/nafsm_eval.sv
rtl/neighbor_adjacency_fsm_unit.sv
sim/tb_neighbor_adjacency_fsm_unit.sv
